// File: rtl/core/active_fault_table_defines.svh
// Assertion macros used by the fault table RTL.
`ifndef ACTIVE_FAULT_TABLE_DEFINES_SVH
`define ACTIVE_FAULT_TABLE_DEFINES_SVH
// Asserts that a condition implies a consequence on the same edge.
`define AFT_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");
// Asserts that a condition implies a consequence on the next edge.
`define AFT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/aft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault table package
// Shared types and constants of the active fault table.
// ----------------------------------------------------------------------------
package aft_pkg;

  localparam logic [7:0] Broadcast = 8'hFF;
  localparam logic [3:0] MinLength = 4'd5;
  localparam logic [2:0] FlashFast = 3'd2;
  localparam logic [2:0] FlashSlow = 3'd6;

  localparam int unsigned BitActive   = 0;
  localparam int unsigned BitAudible  = 1;
  localparam int unsigned BitVisual   = 2;
  localparam int unsigned BitLatching = 3;

  typedef enum logic [1:0] {
    MODE_EVENT = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_OWN_NODE   = 2'd0,
    CFG_FRAME_ID   = 2'd1,
    CFG_EXPIRY     = 2'd2,
    CFG_LEDS       = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OUT_IGNORED   = 3'd0,
    OUT_CLEARED   = 3'd1,
    OUT_UNMATCHED = 3'd2,
    OUT_ADDED     = 3'd3,
    OUT_UPDATED   = 3'd4,
    OUT_EVICTED   = 3'd5,
    OUT_TICK      = 3'd6,
    OUT_QUERY     = 3'd7
  } outcome_e;

  typedef enum logic [1:0] {
    OP_IGNORE = 2'd0,
    OP_FRAME  = 2'd1,
    OP_TICK   = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  // Classified word handed from the front end to the engine.
  typedef struct packed {
    op_e         op;
    logic [7:0]  source;
    logic [7:0]  code;
    logic [7:0]  severity;
    logic [7:0]  flags;
    logic [31:0] now_ms;
    logic [1:0]  alarm;
    logic [2:0]  flash;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  source;
    logic [7:0]  code;
    logic [7:0]  severity;
    logic [7:0]  flags;
    logic [31:0] raised;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DROP,
    ST_WRITE,
    ST_SEV,
    ST_DONE
  } state_e;

endpackage

// File: rtl/core/active_fault_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active fault table
// Table of active faults with filtering, expiry ticks and queries.
// ----------------------------------------------------------------------------
// One word at a time: a new word is taken only while busy is low, and the table
// walk of the engine sets the rate.
// One result per word, shown for one cycle with done_o; it cannot be stalled.
// Reset empties the table and loads the register reset values.
`include "active_fault_table_defines.svh"
module active_fault_table #(
  parameter int unsigned TableDepth = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  mode_i,
  input  logic [10:0] frame_id_i,
  input  logic [3:0]  length_i,
  input  logic [7:0]  source_i,
  input  logic [7:0]  code_i,
  input  logic [7:0]  severity_i,
  input  logic [7:0]  target_i,
  input  logic [7:0]  flag_bits_i,
  input  logic [31:0] now_ms_i,
  output logic        done_o,
  output logic [2:0]  outcome_o,
  output logic [1:0]  alarm_o,
  output logic [2:0]  flash_half_period_o,
  output logic [3:0]  active_count_o,
  output logic [7:0]  highest_severity_o,
  output logic        code_present_o,
  output logic        any_at_least_o,
  output logic [3:0]  expired_count_o
);
  import aft_pkg::*;

  logic [7:0]  own_node_q;
  logic [10:0] frame_id_q;
  logic [31:0] expiry_q;
  logic        leds_q;
  logic        cmd_valid, pop, eng_busy, accept;
  cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_node_q <= 8'd0;
      frame_id_q <= 11'd246;
      expiry_q   <= 32'd30000;
      leds_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OWN_NODE: own_node_q <= cfg_data_i[7:0];
        CFG_FRAME_ID: frame_id_q <= cfg_data_i[10:0];
        CFG_EXPIRY:   expiry_q   <= cfg_data_i;
        CFG_LEDS:     leds_q     <= cfg_data_i[0];
        default:      leds_q     <= leds_q;
      endcase
    end
  end

  assign accept = start && !busy;
  assign busy   = eng_busy;

  aft_front u_front (
    .clk_i, .rst_ni,
    .valid_i          (accept),
    .mode_i, .frame_id_i, .length_i, .source_i, .code_i, .severity_i,
    .target_i, .flag_bits_i, .now_ms_i,
    .own_node_i       (own_node_q),
    .event_frame_id_i (frame_id_q),
    .leds_present_i   (leds_q),
    .pop_i            (pop),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd)
  );

  aft_engine #(.Depth(TableDepth)) u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .expiry_ms_i (expiry_q),
    .pop_o       (pop),
    .busy_o      (eng_busy),
    .done_o, .outcome_o, .alarm_o, .flash_half_period_o, .active_count_o,
    .highest_severity_o, .code_present_o, .any_at_least_o, .expired_count_o
  );

  `AFT_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, accept, busy)
  `AFT_ASSERT_IMPL(a_no_start_done, clk_i, rst_ni, done_o, busy)
  `AFT_ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1, active_count_o <= 4'(TableDepth))

endmodule

// File: rtl/core/aft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault table front end
// Filters and classifies incoming words and works out the alarm reaction.
// ----------------------------------------------------------------------------
module aft_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [1:0]    mode_i,
  input  logic [10:0]   frame_id_i,
  input  logic [3:0]    length_i,
  input  logic [7:0]    source_i,
  input  logic [7:0]    code_i,
  input  logic [7:0]    severity_i,
  input  logic [7:0]    target_i,
  input  logic [7:0]    flag_bits_i,
  input  logic [31:0]   now_ms_i,
  input  logic [7:0]    own_node_i,
  input  logic [10:0]   event_frame_id_i,
  input  logic          leds_present_i,
  input  logic          pop_i,
  output logic          cmd_valid_o,
  output aft_pkg::cmd_t cmd_o
);
  import aft_pkg::*;

  cmd_t cmd_d, cmd_q;
  logic valid_q;
  logic pass;

  always_comb begin
    pass = (frame_id_i == event_frame_id_i) && (length_i >= MinLength) &&
           ((target_i == Broadcast) || (target_i == own_node_i));
    cmd_d = '0;
    cmd_d.source   = source_i;
    cmd_d.code     = code_i;
    cmd_d.severity = severity_i;
    cmd_d.flags    = flag_bits_i;
    cmd_d.now_ms   = now_ms_i;
    unique case (mode_e'(mode_i))
      MODE_EVENT: cmd_d.op = pass ? OP_FRAME : OP_IGNORE;
      MODE_TICK:  cmd_d.op = OP_TICK;
      MODE_QUERY: cmd_d.op = OP_QUERY;
      default:    cmd_d.op = OP_IGNORE;
    endcase
    if (flag_bits_i[BitAudible]) begin
      if (severity_i == 8'd1 || severity_i == 8'd2) begin
        cmd_d.alarm = 2'd1;
      end else if (severity_i == 8'd3) begin
        cmd_d.alarm = 2'd2;
      end
    end
    if (flag_bits_i[BitVisual] && leds_present_i) begin
      cmd_d.flash = (severity_i >= 8'd2) ? FlashFast : FlashSlow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// File: rtl/core/aft_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fault table engine
// Walks the table one entry a cycle to carry out a classified word.
// ----------------------------------------------------------------------------
module aft_engine #(
  parameter int unsigned Depth = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  aft_pkg::cmd_t cmd_i,
  input  logic [31:0]   expiry_ms_i,
  output logic          pop_o,
  output logic          busy_o,
  output logic          done_o,
  output logic [2:0]    outcome_o,
  output logic [1:0]    alarm_o,
  output logic [2:0]    flash_half_period_o,
  output logic [3:0]    active_count_o,
  output logic [7:0]    highest_severity_o,
  output logic          code_present_o,
  output logic          any_at_least_o,
  output logic [3:0]    expired_count_o
);
  import aft_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            tab_q [Depth];
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   hit_q, hit_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   ev_q, ev_d;
  logic [3:0]        exp_q, exp_d;
  logic              pres_q, pres_d, atl_q, atl_d;
  logic [7:0]        max_q, max_d;
  logic [2:0]        out_q, out_d;
  cmd_t              cmd_q;
  state_e            st_q, st_d;

  entry_t            cur, evc, last;
  logic [IdxW-1:0]   ci;
  logic              in_range, expired;
  logic [31:0]       age;

  always_comb begin
    ci       = idx_q[IdxW-1:0];
    in_range = idx_q < cnt_q;
    cur      = tab_q[ci];
    evc      = tab_q[ev_q];
    last     = tab_q[IdxW'(cnt_q - CntW'(1))];
    age      = cmd_q.now_ms - cur.raised;
    expired  = !cur.flags[BitLatching] && (age >= expiry_ms_i);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (cmd_valid_i) st_d = ST_SCAN;
      ST_SCAN: begin
        if (!in_range || (cmd_q.op == OP_IGNORE)) begin
          st_d = (cmd_q.op == OP_FRAME) ? ST_WRITE : ST_SEV;
        end else if (cmd_q.op == OP_FRAME && cur.source == cmd_q.source &&
                     cur.code == cmd_q.code && !found_q) begin
          st_d = ST_WRITE;
        end
      end
      ST_WRITE: st_d = ST_SEV;
      ST_SEV:   if (!in_range) st_d = ST_DONE;
      ST_DONE:  st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    idx_q   <= idx_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    ev_q    <= ev_d;
    exp_q   <= exp_d;
    pres_q  <= pres_d;
    atl_q   <= atl_d;
    max_q   <= max_d;
    out_q   <= out_d;
  end

  // Table writes: update, append, evict and append, or fill a freed slot from the end.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_SCAN && cmd_q.op == OP_TICK && in_range && expired &&
        idx_q != cnt_q - CntW'(1)) begin
      tab_q[ci] <= last;
    end
    if (st_q == ST_WRITE) begin
      if (found_q) begin
        if (cmd_q.flags[BitActive]) begin
          tab_q[hit_q].severity <= cmd_q.severity;
          tab_q[hit_q].flags    <= cmd_q.flags;
          tab_q[hit_q].raised   <= cmd_q.now_ms;
        end else if (CntW'(hit_q) != cnt_q - CntW'(1)) begin
          tab_q[hit_q] <= last;
        end
      end else if (cmd_q.flags[BitActive]) begin
        if (cnt_q >= CntW'(Depth)) begin
          if (CntW'(ev_q) != cnt_q - CntW'(1)) begin
            tab_q[ev_q] <= last;
          end
          tab_q[IdxW'(cnt_q - CntW'(1))] <= '{cmd_q.source, cmd_q.code,
              cmd_q.severity, cmd_q.flags, cmd_q.now_ms};
        end else begin
          tab_q[IdxW'(cnt_q)] <= '{cmd_q.source, cmd_q.code,
              cmd_q.severity, cmd_q.flags, cmd_q.now_ms};
        end
      end
    end
  end

  always_comb begin
    idx_d   = idx_q;
    hit_d   = hit_q;
    found_d = found_q;
    ev_d    = ev_q;
    exp_d   = exp_q;
    pres_d  = pres_q;
    atl_d   = atl_q;
    max_d   = max_q;
    out_d   = out_q;
    cnt_d   = cnt_q;
    unique case (st_q)
      ST_IDLE: begin
        idx_d   = '0;
        found_d = 1'b0;
        hit_d   = '0;
        ev_d    = '0;
        exp_d   = '0;
        pres_d  = 1'b0;
        atl_d   = 1'b0;
        max_d   = '0;
      end
      ST_SCAN: begin
        if (in_range) begin
          unique case (cmd_q.op)
            OP_FRAME: begin
              if (cur.source == cmd_q.source && cur.code == cmd_q.code) begin
                found_d = 1'b1;
                hit_d   = ci;
              end
              if (idx_q != '0 && !cur.flags[BitLatching] &&
                  (evc.flags[BitLatching] || cur.raised < evc.raised)) begin
                ev_d = ci;
              end
              idx_d = idx_q + CntW'(1);
            end
            OP_TICK: begin
              if (expired) begin
                cnt_d = cnt_q - CntW'(1);
                exp_d = exp_q + 4'd1;
              end else begin
                idx_d = idx_q + CntW'(1);
              end
            end
            OP_QUERY: begin
              if (cur.code == cmd_q.code) pres_d = 1'b1;
              if (cur.severity >= cmd_q.severity) atl_d = 1'b1;
              idx_d = idx_q + CntW'(1);
            end
            default: idx_d = idx_q;
          endcase
        end
        unique case (cmd_q.op)
          OP_TICK:  out_d = OUT_TICK;
          OP_QUERY: out_d = OUT_QUERY;
          default:  out_d = OUT_IGNORED;
        endcase
        if (st_d != ST_SCAN) idx_d = '0;
      end
      ST_WRITE: begin
        if (found_q) begin
          if (cmd_q.flags[BitActive]) begin
            out_d = OUT_UPDATED;
          end else begin
            out_d = OUT_CLEARED;
            cnt_d = cnt_q - CntW'(1);
          end
        end else if (!cmd_q.flags[BitActive]) begin
          out_d = OUT_UNMATCHED;
        end else if (cnt_q >= CntW'(Depth)) begin
          out_d = OUT_EVICTED;
        end else begin
          out_d = OUT_ADDED;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_SEV: begin
        if (in_range) begin
          if (cur.severity > max_q) max_d = cur.severity;
          idx_d = idx_q + CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pop_o   = (st_q == ST_IDLE) && cmd_valid_i;
    busy_o  = (st_q != ST_IDLE) || cmd_valid_i;
    done_o  = (st_q == ST_DONE);
  end

  logic reaction;
  assign reaction = (out_q == OUT_ADDED) || (out_q == OUT_UPDATED) ||
                    (out_q == OUT_EVICTED);

  assign outcome_o           = out_q;
  assign alarm_o             = reaction ? cmd_q.alarm : 2'd0;
  assign flash_half_period_o = reaction ? cmd_q.flash : 3'd0;
  assign active_count_o      = 4'(cnt_q);
  assign highest_severity_o  = (cnt_q == '0) ? Broadcast : max_q;
  assign code_present_o      = pres_q;
  assign any_at_least_o      = atl_q;
  assign expired_count_o     = exp_q;

endmodule
